// ===== rtl/core/hrp_pkg.sv =====
package hrp_pkg;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    typedef enum logic [9:0] {
        PH_METHOD   = 10'b00_0000_0001,
        PH_URL      = 10'b00_0000_0010,
        PH_PROTO    = 10'b00_0000_0100,
        PH_PROTO_LF = 10'b00_0000_1000,
        PH_LINE     = 10'b00_0001_0000,
        PH_HELD_CR  = 10'b00_0010_0000,
        PH_KEY      = 10'b00_0100_0000,
        PH_KEY_SP   = 10'b00_1000_0000,
        PH_VALUE    = 10'b01_0000_0000,
        PH_VALUE_LF = 10'b10_0000_0000
    } t_phase;

    typedef enum logic [2:0] {
        CLS_METHOD = 3'd0,
        CLS_URL    = 3'd1,
        CLS_PROTO  = 3'd2,
        CLS_KEY    = 3'd3,
        CLS_VALUE  = 3'd4,
        CLS_DELIM  = 3'd5
    } t_class;

    typedef enum logic [1:0] {
        VD_BUSY   = 2'd0,
        VD_ACCEPT = 2'd1,
        VD_REJECT = 2'd2
    } t_verdict;

    // One queued job: an optional leading CR result, then the main result.
    typedef struct packed {
        logic [7:0] data;
        t_class     cls;
        t_verdict   vd;
        logic       pair;
        t_class     pre_cls;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_q_push;

    typedef struct packed {
        logic   empty;
        t_entry head;
    } t_q_head;

endpackage

// ===== rtl/core/http_request_head_parser_core.sv =====
// Channel  Dir  Handshake              Payload
// s        in   i_s_tvalid/o_s_tready  tdata[7:0] data_byte; tuser[0] end_of_input
// m        out  o_m_tvalid/i_m_tready  tdata[7:0] byte_out, [9:8] verdict;
//                                      tuser[2:0] field_class; tlast last
//
// One byte is accepted per cycle while the result queue has room; a result
// passes through the queue and then the output register before it appears.
// A CR held at a line start and the byte after it give two results, which
// leave the output one after the other; the queue absorbs that and short output stalls,
// and o_s_tready drops while it is full.
// Reset is synchronous, active low; the parser restarts at the method field.
module http_request_head_parser_core
    import hrp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic [0:0]  i_s_tuser,   // [0] end_of_input
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] byte_out, [9:8] verdict
    output logic [2:0]  o_m_tuser,   // [2:0] field_class
    output logic        o_m_tlast
);

    t_q_push  w_push;
    t_q_head  w_head;
    logic     w_full;
    logic     w_pop;
    logic     w_accept;
    logic [7:0] w_byte;
    t_class   w_cls;
    t_verdict w_vd;

    assign o_s_tready = !w_full;
    assign w_accept   = i_s_tvalid && !w_full;

    hrp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_data_byte    (i_s_tdata),
        .i_end_of_input (i_s_tuser[0]),
        .o_push         (w_push)
    );

    hrp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    hrp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_byte  (w_byte),
        .o_cls   (w_cls),
        .o_vd    (w_vd),
        .o_last  (o_m_tlast)
    );

    assign o_m_tdata = {6'b0, w_vd, w_byte};
    assign o_m_tuser = w_cls;

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push.valid && w_full))
        else $error("push into full result queue");

    a_pair_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !w_head.empty)
        else $error("leading CR shown without its entry queued");

    a_accept_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && w_vd == VD_ACCEPT) |-> (o_m_tlast && w_cls == CLS_DELIM))
        else $error("accept verdict on a non-final or non-delimiter result");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |=> (o_m_tvalid && o_m_tlast))
        else $error("queue entry retired without its final result");
`endif

endmodule

// ===== rtl/core/hrp_front.sv =====
module hrp_front
    import hrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_input,
    output t_q_push    o_push
);

    t_phase r_phase, n_phase;
    t_entry w_entry;
    logic   w_emit;

    always_comb begin
        n_phase       = r_phase;
        w_emit        = 1'b1;
        w_entry.data  = i_data_byte;
        w_entry.cls   = CLS_DELIM;
        w_entry.vd    = VD_BUSY;
        w_entry.pair  = 1'b0;
        w_entry.pre_cls = CLS_KEY;
        if (i_end_of_input) begin
            w_entry.data = '0;
            w_entry.vd   = VD_REJECT;
            n_phase      = PH_METHOD;
        end else begin
            case (r_phase)
                PH_URL: begin
                    if (i_data_byte == CH_SP) n_phase = PH_PROTO;
                    else w_entry.cls = CLS_URL;
                end
                PH_PROTO: begin
                    if (i_data_byte == CH_CR) n_phase = PH_PROTO_LF;
                    else w_entry.cls = CLS_PROTO;
                end
                PH_PROTO_LF, PH_VALUE_LF, PH_KEY_SP: begin
                    if (r_phase == PH_KEY_SP && i_data_byte == CH_SP) begin
                        n_phase = PH_VALUE;
                    end else if (r_phase != PH_KEY_SP && i_data_byte == CH_LF) begin
                        n_phase = PH_LINE;
                    end else begin
                        w_entry.vd = VD_REJECT;
                        n_phase    = PH_METHOD;
                    end
                end
                PH_LINE, PH_HELD_CR, PH_KEY: begin
                    if (r_phase == PH_LINE && i_data_byte == CH_CR) begin
                        // hold the CR until the next byte decides
                        w_emit  = 1'b0;
                        n_phase = PH_HELD_CR;
                    end else if (r_phase == PH_HELD_CR && i_data_byte == CH_LF) begin
                        w_entry.pair    = 1'b1;
                        w_entry.pre_cls = CLS_DELIM;
                        w_entry.vd      = VD_ACCEPT;
                        n_phase         = PH_METHOD;
                    end else begin
                        w_entry.pair = (r_phase == PH_HELD_CR);
                        if (i_data_byte == CH_COLON) begin
                            n_phase = PH_KEY_SP;
                        end else begin
                            w_entry.cls = CLS_KEY;
                            n_phase     = PH_KEY;
                        end
                    end
                end
                PH_VALUE: begin
                    if (i_data_byte == CH_CR) n_phase = PH_VALUE_LF;
                    else w_entry.cls = CLS_VALUE;
                end
                default: begin
                    if (i_data_byte == CH_SP) begin
                        n_phase = PH_URL;
                    end else begin
                        w_entry.cls = CLS_METHOD;
                        n_phase     = PH_METHOD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_METHOD;
        end else if (i_accept) begin
            r_phase <= n_phase;
        end
    end

    assign o_push.valid = i_accept && w_emit;
    assign o_push.entry = w_entry;

endmodule

// ===== rtl/core/hrp_queue.sv =====
module hrp_queue
    import hrp_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_push i_push,
    input  logic    i_pop,
    output logic    o_full,
    output t_q_head o_head
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_entry          r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_cnt <= r_cnt + CW'(i_push.valid) - CW'(i_pop);
        end
    end

    assign o_full       = (r_cnt == CW'(DEPTH));
    assign o_head.empty = (r_cnt == '0);
    assign o_head.head  = r_mem[r_rd];

endmodule

// ===== rtl/core/hrp_back.sv =====
module hrp_back
    import hrp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_head    i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output t_class     o_cls,
    output t_verdict   o_vd,
    output logic       o_last
);

    logic       r_valid;
    logic       r_half;
    logic [7:0] r_byte;
    t_class     r_cls;
    t_verdict   r_vd;
    logic       r_last;
    logic       w_load;
    logic       w_pre;

    assign w_load = (!r_valid || i_ready) && !i_head.empty;
    // first half of a held-CR pair: emit the CR, keep the entry at the head
    assign w_pre  = i_head.head.pair && !r_half;
    assign o_pop  = w_load && !w_pre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_half  <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
            r_half  <= w_pre;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (w_pre) begin
                r_byte <= CH_CR;
                r_cls  <= i_head.head.pre_cls;
                r_vd   <= VD_BUSY;
                r_last <= 1'b0;
            end else begin
                r_byte <= i_head.head.data;
                r_cls  <= i_head.head.cls;
                r_vd   <= i_head.head.vd;
                r_last <= 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_cls   = r_cls;
    assign o_vd    = r_vd;
    assign o_last  = r_last;

endmodule
